### hdl/write_range_adjacency_tracker_macros.svh
// ----------------------------------------------------------------------------
// write range adjacency tracker assertion macros
// concurrent assertion shorthands clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef WRITE_RANGE_ADJACENCY_TRACKER_MACROS_SVH
`define WRITE_RANGE_ADJACENCY_TRACKER_MACROS_SVH

// same-cycle implication
`define WRAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WRAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/wrat_pkg.sv
// ----------------------------------------------------------------------------
// wrat_pkg
// shared widths and types of the write range adjacency tracker
// ----------------------------------------------------------------------------
`default_nettype none

package wrat_pkg;

  localparam int HistDepth = 5;
  localparam int AddrBits  = 32;
  localparam int PointBits = 64;
  localparam int SizeBits  = 8;
  localparam int IdxBits   = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int CntBits   = $clog2(HistDepth + 1);

  typedef logic [PointBits-1:0] point_t;
  typedef logic [AddrBits-1:0]  addr_t;
  typedef logic [SizeBits-1:0]  size_t;
  typedef logic [IdxBits-1:0]   idx_t;

  // one history entry
  typedef struct packed {
    point_t pt;
    addr_t  start;
    addr_t  stop;
  } slot_t;

  // sequencer to pair buffer
  typedef struct packed {
    logic   push;
    logic   flush;
    point_t first;
    point_t second;
  } pair_req_t;

endpackage

`default_nettype wire

### hdl/wrat_slot_mem.sv
// ----------------------------------------------------------------------------
// wrat_slot_mem
// history ring storage: one write and one registered read port per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wrat_slot_mem (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rd_en_i,
  input  wrat_pkg::idx_t  rd_idx_i,
  output wrat_pkg::slot_t rd_data_o,
  input  logic           wr_en_i,
  input  wrat_pkg::idx_t  wr_idx_i,
  input  wrat_pkg::slot_t wr_data_i
);
  import wrat_pkg::*;

  slot_t                mem [HistDepth];
  logic [HistDepth-1:0] vld_q;
  slot_t                rd_raw_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_raw_q <= mem[rd_idx_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_idx_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_raw_q : '0;

endmodule

`default_nettype wire

### hdl/wrat_pair_buf.sv
// ----------------------------------------------------------------------------
// wrat_pair_buf
// holds one pending pair until the next is known, then the output register
// ----------------------------------------------------------------------------
`default_nettype none

module wrat_pair_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wrat_pkg::pair_req_t req_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wrat_pkg::point_t    first_point_o,
  output wrat_pkg::point_t    second_point_o,
  output logic               last_pair_o
);
  import wrat_pkg::*;

  logic   pend_vld_q;
  point_t pend_first_q;
  point_t pend_second_q;
  logic   out_vld_q;
  logic   out_last_q;
  point_t out_first_q;
  point_t out_second_q;
  logic   do_push;
  logic   do_flush;

  // a pending pair can only move on when the output register frees up
  assign ready_o  = !pend_vld_q || !out_vld_q || !out_stall_i;
  assign do_push  = ready_o && req_i.push;
  assign do_flush = ready_o && req_i.flush && pend_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      // a reload wins over the drain of the current pair
      if ((do_push && pend_vld_q) || do_flush) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (do_push) begin
        pend_vld_q <= 1'b1;
      end else if (do_flush) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      pend_first_q  <= req_i.first;
      pend_second_q <= req_i.second;
    end
    if ((do_push && pend_vld_q) || do_flush) begin
      out_first_q  <= pend_first_q;
      out_second_q <= pend_second_q;
      out_last_q   <= do_flush;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign first_point_o  = out_first_q;
  assign second_point_o = out_second_q;
  assign last_pair_o    = out_last_q;

endmodule

`default_nettype wire

### hdl/write_range_adjacency_tracker.sv
// ----------------------------------------------------------------------------
// write_range_adjacency_tracker
// finds program points whose memory writes lie back to back in memory
// ----------------------------------------------------------------------------
// Each accepted write (program point, address, size) is checked against a
// ring of the five most recent write ranges. Slots are visited in index order
// and every slot of another program point whose range ends where the write
// starts gives the pair (slot point, write point); failing that, a slot whose
// range starts where the write ends gives (write point, slot point). Pairs
// leave one per transfer, last_pair_o marking the final one of a write; a
// write with no adjacency gives no transfer at all. The newest slot is then
// extended or replaced (same point) or the ring advances (new point).
// Addresses wrap at 2^32. The ring sits in a small memory with a registered
// read; the sequencer reads one slot per cycle while no found pair waits on
// the pair buffer, so a write takes longer while output stall holds back a
// finished pair. Only one write is in flight: the input stall stays high
// from the cycle after a transfer until its write-back.
// After reset every slot reads as point 0 with range [0,0) and takes part in
// matching; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module write_range_adjacency_tracker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  wrat_pkg::point_t   program_point_i,
  input  wrat_pkg::addr_t    write_address_i,
  input  wrat_pkg::size_t    write_size_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wrat_pkg::point_t   first_point_o,
  output wrat_pkg::point_t   second_point_o,
  output logic              last_pair_o
);
  import wrat_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  state_e               state_q;
  logic [CntBits-1:0]   rd_idx_q;   // next slot to read, runs up to HistDepth
  idx_t                 cmp_idx_q;  // slot whose read data is on the port
  logic                 cmp_vld_q;
  idx_t                 newest_q;

  // the write under work
  point_t pt_q;
  addr_t  lo_q;
  addr_t  hi_q;
  slot_t  cur_q;                    // copy of the newest slot, caught during scan

  logic      in_xfer;
  slot_t     rd_data;
  logic      rd_en;
  logic      more_reads;
  logic      hit_end;
  logic      hit_start;
  logic      match;
  logic      advance;
  logic      buf_ready;
  pair_req_t req;
  logic      wr_en;
  idx_t      wr_idx;
  slot_t     wr_data;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // ---- slot compare on the registered read data ----
  assign hit_end   = (lo_q == rd_data.stop);
  assign hit_start = (hi_q == rd_data.start);
  assign match     = (state_q == ST_SCAN) && cmp_vld_q && (rd_data.pt != pt_q)
                     && (hit_end || hit_start);

  // a found pair waits while the pending slot cannot drain
  assign advance    = !match || buf_ready;
  assign more_reads = (rd_idx_q < CntBits'(HistDepth));
  assign rd_en      = (state_q == ST_SCAN) && advance && more_reads;

  always_comb begin
    req        = '0;
    req.push   = match;
    req.flush  = (state_q == ST_FIN);
    // end test wins when both hold
    req.first  = hit_end ? rd_data.pt : pt_q;
    req.second = hit_end ? pt_q : rd_data.pt;
  end

  // ---- write-back of the newest slot ----
  always_comb begin
    wr_en   = (state_q == ST_FIN) && buf_ready;
    wr_idx  = newest_q;
    wr_data = cur_q;
    if (cur_q.pt == pt_q) begin
      if (cur_q.start == hi_q) begin
        // grows downward
        wr_data.start = lo_q;
      end else if (cur_q.stop == lo_q) begin
        // grows upward
        wr_data.stop = hi_q;
      end else begin
        wr_data.start = lo_q;
        wr_data.stop  = hi_q;
      end
    end else begin
      wr_idx        = (newest_q == idx_t'(HistDepth - 1)) ? '0 : newest_q + 1'b1;
      wr_data.pt    = pt_q;
      wr_data.start = lo_q;
      wr_data.stop  = hi_q;
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_idx_q  <= '0;
      cmp_idx_q <= '0;
      cmp_vld_q <= 1'b0;
      newest_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            rd_idx_q  <= '0;
            cmp_vld_q <= 1'b0;
            state_q   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (advance) begin
            if (more_reads) begin
              cmp_vld_q <= 1'b1;
              cmp_idx_q <= rd_idx_q[IdxBits-1:0];
              rd_idx_q  <= rd_idx_q + 1'b1;
            end else begin
              cmp_vld_q <= 1'b0;
              state_q   <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          // last pending pair goes out tagged as final
          if (buf_ready) begin
            newest_q <= wr_idx;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // ---- payload of the write under work ----
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pt_q <= program_point_i;
      lo_q <= write_address_i;
      hi_q <= write_address_i + AddrBits'(write_size_i);
    end
    if ((state_q == ST_SCAN) && advance && cmp_vld_q && (cmp_idx_q == newest_q)) begin
      cur_q <= rd_data;
    end
  end

  wrat_slot_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_idx_i  (rd_idx_q[IdxBits-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data)
  );

  wrat_pair_buf u_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .ready_o        (buf_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .first_point_o  (first_point_o),
    .second_point_o (second_point_o),
    .last_pair_o    (last_pair_o)
  );

endmodule

`default_nettype wire

### hdl/wrat_checker.sv
// ----------------------------------------------------------------------------
// wrat_checker
// port-level checks of the write range adjacency tracker, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "write_range_adjacency_tracker_macros.svh"

module wrat_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_o,
  input  wrat_pkg::point_t program_point_i,
  input  wrat_pkg::addr_t  write_address_i,
  input  wrat_pkg::size_t  write_size_i,
  input  logic            out_valid_o,
  input  logic            out_stall_i,
  input  wrat_pkg::point_t first_point_o,
  input  wrat_pkg::point_t second_point_o,
  input  logic            last_pair_o
);
  import wrat_pkg::*;

  // stalled pair holds
  `WRAT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(first_point_o) && $stable(second_point_o) && $stable(last_pair_o),
    "stalled output pair changed")

  // one write at a time: busy right after a transfer
  `WRAT_ASSERT_NEXT(a_busy_after_xfer, in_valid_i && !in_stall_o, in_stall_o,
    "input taken again before write-back")

  // stalled write holds its payload
  `WRAT_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o,
    $stable(program_point_i) && $stable(write_address_i) && $stable(write_size_i),
    "stalled write payload changed")

endmodule

bind write_range_adjacency_tracker wrat_checker u_wrat_checker (.*);

`default_nettype wire
